// ===== hdl/ggs_pkg.sv =====
// Shared types, constants and angle helpers for the goto-goal steering block.
`default_nettype none
package ggs_pkg;

  localparam int DW    = 25;
  localparam int SQ_W  = 50;
  localparam int XW    = 44;
  localparam int ZW    = 32;
  localparam int CNT_W = 5;
  localparam int AW    = 19;

  typedef logic signed [AW-1:0] ang_t;

  typedef enum logic [1:0] {
    MODE_GOING    = 2'd0,
    MODE_ACHIEVED = 2'd1
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_DIST, ST_CHECK, ST_BEAR, ST_ERR,
    ST_BACK, ST_DEC, ST_SPMUL, ST_SPROOT, ST_SPWAIT, ST_FIN
  } state_e;

  localparam logic [2:0] REG_GOAL_X     = 3'd0;
  localparam logic [2:0] REG_GOAL_Y     = 3'd1;
  localparam logic [2:0] REG_CLOSE_DIST = 3'd2;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd3;
  localparam logic [2:0] REG_TURN_SPEED = 3'd4;
  localparam logic [2:0] REG_TURN_AMT   = 3'd5;

  localparam ang_t FULL_TURN = 19'sd36000;
  localparam ang_t HALF_TURN = 19'sd18000;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [CNT_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 32'sd294912000;
      5'd1:  r = 32'sd174096719;
      5'd2:  r = 32'sd91987925;
      5'd3:  r = 32'sd46694507;
      5'd4:  r = 32'sd23437865;
      5'd5:  r = 32'sd11730558;
      5'd6:  r = 32'sd5866610;
      5'd7:  r = 32'sd2933484;
      5'd8:  r = 32'sd1466764;
      5'd9:  r = 32'sd733385;
      5'd10: r = 32'sd366693;
      5'd11: r = 32'sd183346;
      5'd12: r = 32'sd91674;
      5'd13: r = 32'sd45837;
      5'd14: r = 32'sd22918;
      5'd15: r = 32'sd11459;
      5'd16: r = 32'sd5730;
      5'd17: r = 32'sd2865;
      5'd18: r = 32'sd1432;
      5'd19: r = 32'sd716;
      5'd20: r = 32'sd358;
      5'd21: r = 32'sd179;
      5'd22: r = 32'sd90;
      5'd23: r = 32'sd45;
      5'd24: r = 32'sd22;
      5'd25: r = 32'sd11;
      5'd26: r = 32'sd6;
      5'd27: r = 32'sd3;
      5'd28: r = 32'sd1;
      5'd29: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Wraps an angle below five half turns in magnitude into (-18000, 18000].
  function automatic ang_t norm_ang(input ang_t v);
    ang_t r;
    r = v;
    if (r > HALF_TURN) r = r - FULL_TURN;
    if (r > HALF_TURN) r = r - FULL_TURN;
    if (r <= -HALF_TURN) r = r + FULL_TURN;
    if (r <= -HALF_TURN) r = r + FULL_TURN;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ggs_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module ggs_isqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ggs_pkg::SQ_W-1:0]     operand_i,
  output logic                              busy_o,
  output logic [ggs_pkg::SQ_W/2-1:0]        root_o
);
  localparam int W = ggs_pkg::SQ_W;
  localparam int STEPS = W / 2;

  logic [W-1:0] n_q, res_q, bit_q;
  logic [W-1:0] sum;
  logic [ggs_pkg::CNT_W-1:0] cnt_q;
  logic busy_q;

  assign sum = res_q + bit_q;
  assign busy_o = busy_q;
  assign root_o = res_q[STEPS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ggs_pkg::CNT_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= operand_i;
      res_q <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (n_q >= sum) begin
        n_q   <= n_q - sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ggs_cordic.sv =====
// Iterative vectoring CORDIC that gives the bearing of a vector in centidegrees.
`default_nettype none
module ggs_cordic #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic signed [ggs_pkg::DW-1:0]   dx_i,
  input  wire logic signed [ggs_pkg::DW-1:0]   dy_i,
  output logic                                 busy_o,
  output logic signed [15:0]                   angle_o
);
  localparam int XW = ggs_pkg::XW;
  localparam int ZW = ggs_pkg::ZW;
  localparam int DW = ggs_pkg::DW;
  localparam logic signed [ZW-1:0] QUARTER = 32'sd589824000;

  logic signed [XW-1:0] x_q, y_q, xs, ys, xi, yi;
  logic signed [ZW-1:0] z_q, zr;
  logic [ggs_pkg::CNT_W-1:0] cnt_q;
  logic busy_q, zero_q;
  ggs_pkg::ang_t an;

  assign xi = {{(XW-DW-16){dx_i[DW-1]}}, dx_i, 16'b0};
  assign yi = {{(XW-DW-16){dy_i[DW-1]}}, dy_i, 16'b0};
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign zr = (z_q + ZW'(32768)) >>> 16;
  assign an = ggs_pkg::norm_ang(zr[ggs_pkg::AW-1:0]);
  assign angle_o = zero_q ? 16'sd0 : an[15:0];
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ggs_pkg::CNT_W'(CORDIC_ITERATIONS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (dx_i == '0) && (dy_i == '0);
      if (dx_i < 0) begin
        if (dy_i >= 0) begin
          x_q <= yi;
          y_q <= -xi;
          z_q <= QUARTER;
        end else begin
          x_q <= -yi;
          y_q <= xi;
          z_q <= -QUARTER;
        end
      end else begin
        x_q <= xi;
        y_q <= yi;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ggs_pkg::atan_lut(cnt_q);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ggs_pkg::atan_lut(cnt_q);
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/goto_goal_steering_top.sv =====
// Top level of the goto-goal steering block: sequencer, shared multiplier and registers.
// A tick toward the goal waits twice on the shared square root unit, once for the distance
// and once for the speed, and the CORDIC steps run beside the first wait. A tick inside the
// close distance ends after the distance check at rest and skips the speed root while moving;
// after the goal is achieved the sequencer goes from accept straight to the output stage. A
// new tick is taken in the cycle after a word is loaded.
// Reset loads the register defaults and puts the block in the going-to-goal mode.
`default_nettype none
module goto_goal_steering_top #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // robot_x[23:0], robot_y[47:24], robot_heading[63:48], robot_speed[78:64],
  // limit_active[79], speed_limit[93:80], zeros above
  input  wire logic [95:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // issued[0], heading_absolute[1], heading_value[18:2], speed_command[32:19],
  // goal_achieved[33], zeros above
  output logic [39:0]      m_axis_tdata_o
);
  localparam int DW = ggs_pkg::DW;
  localparam int SQ_W = ggs_pkg::SQ_W;

  ggs_pkg::state_e state_q, state_d;
  ggs_pkg::mode_e  mode_q;
  logic tdir_q;

  logic signed [23:0] goal_x_q, goal_y_q;
  logic [15:0] close_q;
  logic [13:0] max_q, stta_q;
  logic [14:0] turn_q;

  logic signed [15:0] head_q;
  logic signed [14:0] vel_q;
  logic lim_act_q;
  logic [13:0] lim_q;
  logic signed [DW-1:0] dx_q, dy_q, dx_in, dy_in;
  logic [SQ_W-1:0] prod_q, prod2_q;
  logic [DW-1:0] dist_q;
  logic signed [15:0] ang_q;
  ggs_pkg::ang_t back_q;

  logic r_issued_q, r_habs_q, r_ach_q;
  logic signed [16:0] r_hval_q;
  logic [13:0] r_spd_q;
  logic m_valid_q;
  logic [39:0] m_data_q;

  logic s_fire, sq_start, sq_busy, cd_start, cd_busy, close_w, slow_w, load_out;
  logic [SQ_W-1:0] sq_op;
  logic [DW-1:0] sq_root;
  logic signed [15:0] cd_angle;
  logic signed [DW:0] mul_a, mul_b;
  logic signed [2*DW+1:0] mul_p;
  ggs_pkg::ang_t err_w, tsigned, diff_w, diff_abs, t_ext;

  assign s_axis_tready_o = (state_q == ggs_pkg::ST_IDLE);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o = m_data_q;

  assign dx_in = DW'(goal_x_q) - DW'($signed(s_axis_tdata_i[23:0]));
  assign dy_in = DW'(goal_y_q) - DW'($signed(s_axis_tdata_i[47:24]));

  always_comb begin
    case (state_q)
      ggs_pkg::ST_SQX:   begin mul_a = {dx_q[DW-1], dx_q}; mul_b = {dx_q[DW-1], dx_q}; end
      ggs_pkg::ST_SQY:   begin mul_a = {dy_q[DW-1], dy_q}; mul_b = {dy_q[DW-1], dy_q}; end
      default:           begin mul_a = {1'b0, dist_q}; mul_b = (DW+1)'(400); end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign sq_op = (state_q == ggs_pkg::ST_ROOT) ? prod_q + prod2_q : prod_q;
  assign sq_start = (state_q == ggs_pkg::ST_ROOT) || (state_q == ggs_pkg::ST_SPROOT);
  assign cd_start = s_fire && (mode_q == ggs_pkg::MODE_GOING);

  ggs_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (sq_op),
    .busy_o    (sq_busy),
    .root_o    (sq_root)
  );

  ggs_cordic #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start),
    .dx_i    (dx_in),
    .dy_i    (dy_in),
    .busy_o  (cd_busy),
    .angle_o (cd_angle)
  );

  assign close_w = {{(DW-16){1'b0}}, close_q} > dist_q;
  assign slow_w = (vel_q > -15'sd5) && (vel_q < 15'sd5);
  assign t_ext = ggs_pkg::AW'(turn_q);
  assign tsigned = tdir_q ? -t_ext : t_ext;
  assign err_w = ggs_pkg::norm_ang(ggs_pkg::AW'(ang_q) - ggs_pkg::AW'(head_q));
  assign diff_w = ggs_pkg::norm_ang(ggs_pkg::AW'(ang_q) - back_q);
  assign diff_abs = (diff_w < 0) ? -diff_w : diff_w;
  assign load_out = (state_q == ggs_pkg::ST_FIN) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ggs_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_d = (mode_q == ggs_pkg::MODE_GOING) ? ggs_pkg::ST_SQX : ggs_pkg::ST_FIN;
        end
      end
      ggs_pkg::ST_SQX:    state_d = ggs_pkg::ST_SQY;
      ggs_pkg::ST_SQY:    state_d = ggs_pkg::ST_ROOT;
      ggs_pkg::ST_ROOT:   state_d = ggs_pkg::ST_DIST;
      ggs_pkg::ST_DIST:   if (!sq_busy) state_d = ggs_pkg::ST_CHECK;
      ggs_pkg::ST_CHECK:  state_d = (close_w && slow_w) ? ggs_pkg::ST_FIN : ggs_pkg::ST_BEAR;
      ggs_pkg::ST_BEAR:   if (!cd_busy) state_d = ggs_pkg::ST_ERR;
      ggs_pkg::ST_ERR:    state_d = ggs_pkg::ST_BACK;
      ggs_pkg::ST_BACK:   state_d = ggs_pkg::ST_DEC;
      ggs_pkg::ST_DEC:    state_d = close_w ? ggs_pkg::ST_FIN : ggs_pkg::ST_SPMUL;
      ggs_pkg::ST_SPMUL:  state_d = ggs_pkg::ST_SPROOT;
      ggs_pkg::ST_SPROOT: state_d = ggs_pkg::ST_SPWAIT;
      ggs_pkg::ST_SPWAIT: if (!sq_busy) state_d = ggs_pkg::ST_FIN;
      ggs_pkg::ST_FIN:    if (load_out) state_d = ggs_pkg::ST_IDLE;
      default:            state_d = ggs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ggs_pkg::ST_IDLE;
      mode_q    <= ggs_pkg::MODE_GOING;
      tdir_q    <= 1'b0;
      m_valid_q <= 1'b0;
      goal_x_q  <= '0;
      goal_y_q  <= '0;
      close_q   <= 16'd100;
      max_q     <= 14'd400;
      stta_q    <= 14'd150;
      turn_q    <= 15'd1000;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (state_q == ggs_pkg::ST_CHECK && close_w && slow_w) begin
        mode_q <= ggs_pkg::MODE_ACHIEVED;
      end
      if (state_q == ggs_pkg::ST_ERR && (err_w > 19'sd12000 || err_w < -19'sd12000)) begin
        tdir_q <= ~tdir_q;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ggs_pkg::REG_GOAL_X: begin
            goal_x_q <= cfg_data_i;
            mode_q   <= ggs_pkg::MODE_GOING;
            tdir_q   <= 1'b0;
          end
          ggs_pkg::REG_GOAL_Y: begin
            goal_y_q <= cfg_data_i;
            mode_q   <= ggs_pkg::MODE_GOING;
            tdir_q   <= 1'b0;
          end
          ggs_pkg::REG_CLOSE_DIST: close_q <= cfg_data_i[15:0];
          ggs_pkg::REG_MAX_SPEED:  max_q   <= cfg_data_i[13:0];
          ggs_pkg::REG_TURN_SPEED: stta_q  <= cfg_data_i[13:0];
          ggs_pkg::REG_TURN_AMT:   turn_q  <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ggs_pkg::ST_IDLE: begin
        if (s_fire) begin
          dx_q       <= dx_in;
          dy_q       <= dy_in;
          head_q     <= $signed(s_axis_tdata_i[63:48]);
          vel_q      <= $signed(s_axis_tdata_i[78:64]);
          lim_act_q  <= s_axis_tdata_i[79];
          lim_q      <= s_axis_tdata_i[93:80];
          r_issued_q <= 1'b0;
          r_habs_q   <= 1'b0;
          r_hval_q   <= '0;
          r_spd_q    <= '0;
          r_ach_q    <= (mode_q == ggs_pkg::MODE_ACHIEVED);
        end
      end
      ggs_pkg::ST_SQX: prod_q  <= mul_p[SQ_W-1:0];
      ggs_pkg::ST_SQY: prod2_q <= mul_p[SQ_W-1:0];
      ggs_pkg::ST_DIST: dist_q <= sq_root;
      ggs_pkg::ST_CHECK: begin
        r_issued_q <= 1'b1;
        r_ach_q    <= close_w && slow_w;
      end
      ggs_pkg::ST_BEAR: ang_q <= cd_angle;
      ggs_pkg::ST_BACK: begin
        back_q <= ggs_pkg::norm_ang(ggs_pkg::AW'(head_q) - tsigned);
      end
      ggs_pkg::ST_DEC: begin
        if (lim_act_q && lim_q < stta_q) begin
          r_habs_q <= 1'b0;
          r_hval_q <= tsigned[16:0];
        end else if ((diff_abs <<< 1) > t_ext) begin
          r_habs_q <= 1'b1;
          r_hval_q <= 17'(ang_q);
        end else begin
          r_habs_q <= 1'b0;
          r_hval_q <= -tsigned[16:0];
        end
      end
      ggs_pkg::ST_SPMUL: prod_q <= mul_p[SQ_W-1:0];
      ggs_pkg::ST_SPWAIT: begin
        if (!sq_busy) begin
          r_spd_q <= (sq_root > DW'(max_q)) ? max_q : sq_root[13:0];
        end
      end
      default: ;
    endcase
    if (load_out) begin
      m_data_q <= {6'b0, r_ach_q, r_spd_q, r_hval_q, r_habs_q, r_issued_q};
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("input taken while a tick is in work");

  a_achieved_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[33]) |-> (m_data_q[32:2] == '0))
    else $error("achieved word carries a command");

  a_speed_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[0] && !m_data_q[33]) |-> (m_data_q[32:19] <= max_q))
    else $error("speed above the top speed");

endmodule
`default_nettype wire

// ===== tb/goto_goal_steering_top_tb.sv =====
// Self-checking testbench for the goto-goal steering block with an in-bench predictor.
`timescale 1ns / 100ps
`default_nettype none
module goto_goal_steering_top_tb;

  localparam int CORDIC_STEPS = 16;
  localparam int STALL_LIMIT  = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [95:0] in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [39:0] out_data;

  typedef struct packed {
    logic        achieved;
    logic [13:0] speed;
    logic [16:0] heading;
    logic        absolute;
    logic        issued;
  } command_t;

  command_t       expected_cmds[$];
  int unsigned    error_count = 0;
  int unsigned    words_sent = 0;
  int unsigned    words_checked = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    ready_hold = 0;
  bit             quiet = 1'b0;
  bit             timed_out = 1'b0;

  longint goal_x_q, goal_y_q;
  longint close_q, max_spd_q, turn_spd_q, turn_amt_q;
  ggs_pkg::mode_e mode_q;
  bit     turn_neg_q;

  longint atan_steps[32] = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730558,
    5866610, 2933484, 1466764, 733385, 366693, 183346, 91674, 45837, 22918, 11459, 5730,
    2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};

  goto_goal_steering_top #(.CORDIC_ITERATIONS(CORDIC_STEPS)) u_top (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .s_axis_tvalid_i(in_valid), .s_axis_tready_o(in_ready),
    .s_axis_tdata_i(in_data), .m_axis_tvalid_o(out_valid), .m_axis_tready_i(out_ready),
    .m_axis_tdata_o(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint fdiv_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_angle(longint v);
    longint r;
    r = v % 36000;
    if (r < 0) r += 36000;
    if (r > 18000) r -= 36000;
    return r;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint goal_bearing(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 9000 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -9000 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = fdiv_shift(x, i);
      ys = fdiv_shift(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_steps[i];
      end else begin
        x -= ys; y += xs; z -= atan_steps[i];
      end
    end
    return wrap_angle(fdiv_shift(z + 32768, 16));
  endfunction

  function automatic command_t steer_tick(logic [95:0] w);
    command_t c;
    longint rx, ry, head, vel, dx, dy, ang, t, d, hval, back;
    longint unsigned dist_mm, spd;
    bit lim;
    rx = longint'($signed(w[23:0]));
    ry = longint'($signed(w[47:24]));
    head = longint'($signed(w[63:48]));
    vel = longint'($signed(w[78:64]));
    lim = w[79];
    c = '0;
    c.achieved = (mode_q == ggs_pkg::MODE_ACHIEVED);
    if (mode_q != ggs_pkg::MODE_GOING) return c;
    dx = goal_x_q - rx;
    dy = goal_y_q - ry;
    dist_mm = int_root(longint'(dx * dx) + longint'(dy * dy));
    if (dist_mm < close_q && mag(vel) < 5) begin
      mode_q = ggs_pkg::MODE_ACHIEVED;
      c.issued = 1'b1;
      c.achieved = 1'b1;
      return c;
    end
    ang = goal_bearing(dx, dy);
    if (mag(wrap_angle(ang - head)) > 12000) turn_neg_q = ~turn_neg_q;
    d = turn_neg_q ? -1 : 1;
    t = turn_amt_q;
    if (lim && longint'(w[93:80]) < turn_spd_q) begin
      hval = t * d;
    end else begin
      back = wrap_angle(head - t * d);
      if (2 * mag(wrap_angle(ang - back)) > t) begin
        c.absolute = 1'b1;
        hval = ang;
      end else begin
        hval = -t * d;
      end
    end
    if (dist_mm < close_q) begin
      spd = 0;
    end else begin
      spd = int_root(400 * dist_mm);
      if (spd > max_spd_q) spd = max_spd_q;
    end
    c.issued = 1'b1;
    c.heading = hval[16:0];
    c.speed = spd[13:0];
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("MISMATCH word %0d %s: got %0d expected %0d", words_checked, what, got, want);
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ggs_pkg::REG_GOAL_X: begin
        goal_x_q = longint'($signed(value[23:0]));
        mode_q = ggs_pkg::MODE_GOING;
        turn_neg_q = 0;
      end
      ggs_pkg::REG_GOAL_Y: begin
        goal_y_q = longint'($signed(value[23:0]));
        mode_q = ggs_pkg::MODE_GOING;
        turn_neg_q = 0;
      end
      ggs_pkg::REG_CLOSE_DIST: close_q = value & 16'hFFFF;
      ggs_pkg::REG_MAX_SPEED:  max_spd_q = value & 14'h3FFF;
      ggs_pkg::REG_TURN_SPEED: turn_spd_q = value & 14'h3FFF;
      ggs_pkg::REG_TURN_AMT:   turn_amt_q = value & 15'h7FFF;
      default: ;
    endcase
  endtask

  // Drops the input valid, waits for every predicted word, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0 && !timed_out) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_tick(longint rx, longint ry, longint head, longint vel, bit lim,
                           longint limv);
    logic [95:0] w;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    w = '0;
    w[23:0] = rx[23:0];
    w[47:24] = ry[23:0];
    w[63:48] = head[15:0];
    w[78:64] = vel[14:0];
    w[79] = lim;
    w[93:80] = limv[13:0];
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_cmds.push_back(steer_tick(w));
    words_sent++;
  endtask

  task automatic send_random_tick();
    longint rx, ry;
    case ($urandom_range(0, 3))
      0: begin
        rx = longint'($signed(24'($urandom))); ry = longint'($signed(24'($urandom)));
      end
      1: begin
        rx = goal_x_q + $urandom_range(0, 400) - 200;
        ry = goal_y_q + $urandom_range(0, 400) - 200;
      end
      default: begin
        rx = goal_x_q + $urandom_range(0, 40000) - 20000;
        ry = goal_y_q + $urandom_range(0, 40000) - 20000;
      end
    endcase
    send_tick(rx, ry,
      $urandom_range(0, 9) == 0 ? longint'($signed(16'($urandom)))
                                : longint'($urandom_range(0, 36000)) - 18000,
      $urandom_range(0, 3) == 0 ? longint'($urandom_range(0, 10)) - 5
                                : longint'($signed(15'($urandom))),
      $urandom_range(0, 1), $urandom_range(0, 9) == 0 ? $urandom_range(0, 16383)
                                                      : $urandom_range(0, 400));
  endtask

  task automatic test_directed();
    send_tick(0, 0, 0, 100, 0, 0);
    send_tick(-8388608, -8388608, 18000, -10000, 1, 16383);
    send_tick(8388607, 8388607, -18000, 10000, 1, 0);
    send_tick(8388607, -8388608, 32767, -16384, 0, 10000);
    send_tick(-8388608, 8388607, -32768, 16383, 1, 149);
    send_tick(1000, 0, 18000, 50, 0, 0);
    send_tick(0, 1000, 9000, 50, 0, 0);
    send_tick(-500, -500, -4500, 50, 0, 0);
    send_tick(10, 10, 0, 4, 0, 0);
    send_tick(5000, 5000, 0, 0, 0, 0);
    send_tick(0, 0, 0, -4, 0, 0);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(ggs_pkg::REG_GOAL_X, -8388608);
    write_reg(ggs_pkg::REG_GOAL_Y, 8388607);
    write_reg(ggs_pkg::REG_CLOSE_DIST, 65535);
    write_reg(ggs_pkg::REG_MAX_SPEED, 10000);
    write_reg(ggs_pkg::REG_TURN_SPEED, 10000);
    write_reg(ggs_pkg::REG_TURN_AMT, 18000);
    write_reg(3'd7, 5);
    repeat (6) send_random_tick();
    send_tick(-8388608, 8388600, 0, 3, 0, 0);
    drain();
    write_reg(ggs_pkg::REG_GOAL_X, 8388607);
    write_reg(ggs_pkg::REG_GOAL_Y, -8388608);
    write_reg(ggs_pkg::REG_CLOSE_DIST, 0);
    write_reg(ggs_pkg::REG_MAX_SPEED, 0);
    write_reg(ggs_pkg::REG_TURN_SPEED, 0);
    write_reg(ggs_pkg::REG_TURN_AMT, 32767);
    repeat (6) send_random_tick();
    drain();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      write_reg(ggs_pkg::REG_GOAL_X, longint'($urandom_range(0, 20000)) - 10000);
      write_reg(ggs_pkg::REG_GOAL_Y, longint'($urandom_range(0, 20000)) - 10000);
      write_reg(ggs_pkg::REG_CLOSE_DIST,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 500));
      write_reg(ggs_pkg::REG_MAX_SPEED, $urandom_range(0, 10000));
      write_reg(ggs_pkg::REG_TURN_SPEED, $urandom_range(0, 400));
      write_reg(ggs_pkg::REG_TURN_AMT, p == 7 ? $urandom : $urandom_range(0, 18000));
      if (p == 6) quiet = 1'b1;
      repeat (90) send_random_tick();
      drain();
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) out_ready <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(1, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    command_t got, want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        got = command_t'(out_data[33:0]);
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = expected_cmds.pop_front();
          if (got.issued !== want.issued) report_mismatch("issued", got.issued, want.issued);
          if (got.absolute !== want.absolute)
            report_mismatch("heading_absolute", got.absolute, want.absolute);
          if (got.heading !== want.heading)
            report_mismatch("heading_value", got.heading, want.heading);
          if (got.speed !== want.speed) report_mismatch("speed_command", got.speed, want.speed);
          if (got.achieved !== want.achieved)
            report_mismatch("goal_achieved", got.achieved, want.achieved);
        end
        words_checked++;
      end
      if (idle_cycles > STALL_LIMIT) timed_out = 1'b1;
    end
  end

  initial begin
    goal_x_q = 0; goal_y_q = 0; close_q = 100; max_spd_q = 400;
    turn_spd_q = 150; turn_amt_q = 1000; mode_q = ggs_pkg::MODE_GOING; turn_neg_q = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      begin
        test_directed();
        test_config_extremes();
        test_random_phases();
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("goto_goal_steering_top test failed");
      $finish;
    end else begin
      $display("Covered %0d ticks and %0d checked words over extreme and random settings.",
               words_sent, words_checked);
      if (error_count == 0 && expected_cmds.size() == 0) begin
        $display("goto_goal_steering_top test passed");
      end else begin
        $display("goto_goal_steering_top test failed");
      end
      $finish;
    end
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/ggs_pkg.sv
hdl/ggs_isqrt.sv
hdl/ggs_cordic.sv
hdl/goto_goal_steering_top.sv
tb/goto_goal_steering_top_tb.sv
